>>> hdl/tgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Touch gesture recognizer package
// Event codes, gesture codes, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package tgr_pkg;

  localparam int SWIPE_W = 13;
  localparam int TICKS_W = 16;
  localparam int OP_W    = 2;
  localparam int GEST_W  = 3;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  typedef enum logic [OP_W-1:0] {
    OP_X_UPDATE = 2'd0,
    OP_Y_UPDATE = 2'd1,
    OP_LEVEL    = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef enum logic [GEST_W-1:0] {
    GEST_TAP        = 3'd0,
    GEST_DOUBLE_TAP = 3'd1,
    GEST_LONG_PRESS = 3'd2,
    GEST_UP         = 3'd3,
    GEST_DOWN       = 3'd4,
    GEST_LEFT       = 3'd5,
    GEST_RIGHT      = 3'd6
  } gesture_t;

  typedef enum logic [2:0] {
    REG_SWIPE_THRESHOLD  = 3'd0,
    REG_LONG_PRESS_TICKS = 3'd1,
    REG_DOUBLE_TAP_TICKS = 3'd2,
    REG_SWAP_AXES        = 3'd3,
    REG_FLIP_X           = 3'd4,
    REG_FLIP_Y           = 3'd5
  } reg_idx_t;

endpackage
`default_nettype wire

>>> hdl/touch_gesture_recognizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Touch gesture recognizer
// Classifies tap, double tap, long press and four-way swipes from touch events.
// ----------------------------------------------------------------------------
// The block takes one event beat per clock unless the output stalls. A beat is
// held in an input register and is processed once the output register is free
// or being emptied; the gesture it yields is then written to the output register.
// The input register lets one event be taken while a finished gesture still
// waits downstream. Tick events advance the hold timer and the single-tap
// window, so all timing is in ticks, not clock cycles.
module touch_gesture_recognizer #(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // value [COORD_BITS-1:0], wake_only [COORD_BITS], zero padding above.
  input  wire logic [((COORD_BITS + 8) / 8) * 8-1:0] in_tdata,
  // op [1:0].
  input  wire logic [tgr_pkg::OP_W-1:0]             in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // gesture [2:0], zero padding above.
  output logic [7:0]                                out_tdata,
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [tgr_pkg::CFG_AW-1:0]           cfg_paddr,
  input  wire logic [tgr_pkg::CFG_DW-1:0]           cfg_pwdata,
  output logic [tgr_pkg::CFG_DW-1:0]                cfg_prdata,
  output logic                                      cfg_pready
);

  localparam int CW     = COORD_BITS + 1;
  localparam int DW     = COORD_BITS + 2;
  localparam int CMP_W  = (DW > tgr_pkg::SWIPE_W) ? DW : tgr_pkg::SWIPE_W;
  localparam int HC_W   = (TIME_BITS > tgr_pkg::TICKS_W) ? TIME_BITS : tgr_pkg::TICKS_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Configuration registers.
  logic [tgr_pkg::SWIPE_W-1:0] swipe_thr_r;
  logic [tgr_pkg::TICKS_W-1:0] long_press_r;
  logic [tgr_pkg::TICKS_W-1:0] double_tap_r;
  logic                        swap_axes_r;
  logic                        flip_x_r;
  logic                        flip_y_r;
  logic                        cfg_wr;
  tgr_pkg::reg_idx_t           cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = tgr_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swipe_thr_r  <= tgr_pkg::SWIPE_W'(50);
      long_press_r <= tgr_pkg::TICKS_W'(500);
      double_tap_r <= tgr_pkg::TICKS_W'(300);
      swap_axes_r  <= 1'b0;
      flip_x_r     <= 1'b0;
      flip_y_r     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tgr_pkg::REG_SWIPE_THRESHOLD:  swipe_thr_r  <= cfg_pwdata[tgr_pkg::SWIPE_W-1:0];
        tgr_pkg::REG_LONG_PRESS_TICKS: long_press_r <= cfg_pwdata[tgr_pkg::TICKS_W-1:0];
        tgr_pkg::REG_DOUBLE_TAP_TICKS: double_tap_r <= cfg_pwdata[tgr_pkg::TICKS_W-1:0];
        tgr_pkg::REG_SWAP_AXES:        swap_axes_r  <= cfg_pwdata[0];
        tgr_pkg::REG_FLIP_X:           flip_x_r     <= cfg_pwdata[0];
        tgr_pkg::REG_FLIP_Y:           flip_y_r     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tgr_pkg::REG_SWIPE_THRESHOLD:  cfg_prdata = tgr_pkg::CFG_DW'(swipe_thr_r);
      tgr_pkg::REG_LONG_PRESS_TICKS: cfg_prdata = tgr_pkg::CFG_DW'(long_press_r);
      tgr_pkg::REG_DOUBLE_TAP_TICKS: cfg_prdata = tgr_pkg::CFG_DW'(double_tap_r);
      tgr_pkg::REG_SWAP_AXES:        cfg_prdata = tgr_pkg::CFG_DW'(swap_axes_r);
      tgr_pkg::REG_FLIP_X:           cfg_prdata = tgr_pkg::CFG_DW'(flip_x_r);
      tgr_pkg::REG_FLIP_Y:           cfg_prdata = tgr_pkg::CFG_DW'(flip_y_r);
      default:                       cfg_prdata = '0;
    endcase
  end

  // Input register.
  logic                  in_valid_r;
  tgr_pkg::op_t          in_op_r;
  logic [COORD_BITS-1:0] in_value_r;
  logic                  in_wake_r;
  logic                  advance;

  assign advance   = in_valid_r & (~out_tvalid | out_tready);
  assign in_tready = ~in_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r    <= tgr_pkg::op_t'(in_tuser);
      in_value_r <= in_tdata[COORD_BITS-1:0];
      in_wake_r  <= in_tdata[COORD_BITS];
    end
  end

  // Gesture state.
  logic [COORD_BITS-1:0] raw_x_r, raw_x_nxt;
  logic [COORD_BITS-1:0] raw_y_r, raw_y_nxt;
  logic signed [CW-1:0]  start_x_r, start_x_nxt;
  logic signed [CW-1:0]  start_y_r, start_y_nxt;
  logic signed [CW-1:0]  last_x_r, last_x_nxt;
  logic signed [CW-1:0]  last_y_r, last_y_nxt;
  logic [TIME_BITS-1:0]  hold_r, hold_nxt;
  logic                  touching_r, touching_nxt;
  logic                  swallow_r, swallow_nxt;
  logic                  pending_r, pending_nxt;
  logic [TIME_BITS-1:0]  countdown_r, countdown_nxt;

  logic signed [CW-1:0]  proj_a;
  logic signed [CW-1:0]  proj_b;
  logic signed [CW-1:0]  proj_x;
  logic signed [CW-1:0]  proj_y;
  logic signed [DW-1:0]  dx;
  logic signed [DW-1:0]  dy;
  logic [DW-1:0]         ax;
  logic [DW-1:0]         ay;
  logic                  is_swipe;
  logic                  is_long;
  logic [HC_W-1:0]       dt_ext;
  logic [TIME_BITS-1:0]  dt_load;
  logic                  level_down;
  logic                  res_valid;
  tgr_pkg::gesture_t     res_gesture;

  always_comb begin
    proj_a = swap_axes_r ? CW'(raw_y_r) : CW'(raw_x_r);
    proj_b = swap_axes_r ? CW'(raw_x_r) : CW'(raw_y_r);
    proj_x = flip_x_r ? -proj_a : proj_a;
    proj_y = flip_y_r ? -proj_b : proj_b;

    dx = DW'(last_x_r) - DW'(start_x_r);
    dy = DW'(last_y_r) - DW'(start_y_r);
    ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ay = dy[DW-1] ? DW'(-dy) : DW'(dy);

    is_swipe = (CMP_W'(ax) >= CMP_W'(swipe_thr_r)) || (CMP_W'(ay) >= CMP_W'(swipe_thr_r));
    is_long  = HC_W'(hold_r) >= HC_W'(long_press_r);
    dt_ext   = HC_W'(double_tap_r);
    dt_load  = (dt_ext > HC_W'(TIME_MAX)) ? TIME_MAX : dt_ext[TIME_BITS-1:0];
    level_down = |in_value_r;
  end

  always_comb begin
    raw_x_nxt     = raw_x_r;
    raw_y_nxt     = raw_y_r;
    start_x_nxt   = start_x_r;
    start_y_nxt   = start_y_r;
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    hold_nxt      = hold_r;
    touching_nxt  = touching_r;
    swallow_nxt   = swallow_r;
    pending_nxt   = pending_r;
    countdown_nxt = countdown_r;
    res_valid     = 1'b0;
    res_gesture   = tgr_pkg::GEST_TAP;

    if (advance) begin
      case (in_op_r)
        tgr_pkg::OP_X_UPDATE: raw_x_nxt = in_value_r;
        tgr_pkg::OP_Y_UPDATE: raw_y_nxt = in_value_r;
        tgr_pkg::OP_LEVEL: begin
          if (level_down && !touching_r) begin
            touching_nxt = 1'b1;
            hold_nxt     = '0;
            start_x_nxt  = proj_x;
            start_y_nxt  = proj_y;
            last_x_nxt   = proj_x;
            last_y_nxt   = proj_y;
            swallow_nxt  = in_wake_r;
          end else if (level_down) begin
            last_x_nxt = proj_x;
            last_y_nxt = proj_y;
          end else if (touching_r) begin
            touching_nxt = 1'b0;
            if (!swallow_r) begin
              if (is_swipe || is_long || pending_r) begin
                pending_nxt   = 1'b0;
                countdown_nxt = '0;
                res_valid     = 1'b1;
                if (is_swipe) begin
                  if (ax > ay) begin
                    res_gesture = dx > 0 ? tgr_pkg::GEST_RIGHT : tgr_pkg::GEST_LEFT;
                  end else begin
                    res_gesture = dy > 0 ? tgr_pkg::GEST_DOWN : tgr_pkg::GEST_UP;
                  end
                end else if (is_long) begin
                  res_gesture = tgr_pkg::GEST_LONG_PRESS;
                end else begin
                  res_gesture = tgr_pkg::GEST_DOUBLE_TAP;
                end
              end else begin
                pending_nxt   = 1'b1;
                countdown_nxt = dt_load;
              end
            end
          end
        end
        tgr_pkg::OP_TICK: begin
          if (touching_r && hold_r != TIME_MAX) begin
            hold_nxt = hold_r + TIME_BITS'(1);
          end
          if (pending_r) begin
            if (countdown_r <= TIME_BITS'(1)) begin
              pending_nxt   = 1'b0;
              countdown_nxt = '0;
              res_valid     = 1'b1;
              res_gesture   = tgr_pkg::GEST_TAP;
            end else begin
              countdown_nxt = countdown_r - TIME_BITS'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_x_r     <= '0;
      raw_y_r     <= '0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      hold_r      <= '0;
      touching_r  <= 1'b0;
      swallow_r   <= 1'b0;
      pending_r   <= 1'b0;
      countdown_r <= '0;
    end else begin
      raw_x_r     <= raw_x_nxt;
      raw_y_r     <= raw_y_nxt;
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      hold_r      <= hold_nxt;
      touching_r  <= touching_nxt;
      swallow_r   <= swallow_nxt;
      pending_r   <= pending_nxt;
      countdown_r <= countdown_nxt;
    end
  end

  // Output register.
  logic              out_valid_r;
  tgr_pkg::gesture_t out_gesture_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_gesture_r <= res_gesture;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8 - tgr_pkg::GEST_W){1'b0}}, out_gesture_r};

endmodule
`default_nettype wire
